/* hw/rtl/otus_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package otus_pkg;

   // stream positions and unit lengths share one width
   localparam int OFFSET_W    = 32;
   localparam int CAP_W       = 13;
   localparam int NUMBER_W    = 12;

   localparam logic [CAP_W-1:0] UNIT_CAP  = 13'd4096;
   localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

   localparam logic [3:0] KIND_TEMPORAL_DELIM = 4'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       end_of_stream;
   } otus_req_type;

   typedef struct packed {
      logic [31:0] unit_offset;
      logic [31:0] unit_length;
      logic [11:0] unit_number;
      logic        halted_by_cap;
      logic        last_result;
   } otus_rsp_type;

   // one reported unit before the length is formed
   typedef struct packed {
      logic [OFFSET_W-1:0] start_pos;
      logic [OFFSET_W-1:0] end_pos;
      logic [NUMBER_W-1:0] number;
      logic                halted;
      logic                last;
   } otus_unit_type;

   // everything one input byte reports: one unit, sometimes two
   typedef struct packed {
      otus_unit_type first;
      otus_unit_type second;
      logic          has_second;
   } otus_entry_type;

endpackage

`default_nettype wire

/* hw/rtl/otus_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module otus_front import otus_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire otus_req_type     req,
   input  wire logic [CAP_W-1:0] cap_setting,
   output logic                  push,
   output otus_entry_type        entry
);

   typedef enum logic [6:0] {
      PH_HEADER  = 7'b0000001,
      PH_EXT     = 7'b0000010,
      PH_SIZE    = 7'b0000100,
      PH_PAYLOAD = 7'b0001000,
      PH_TO_END  = 7'b0010000,
      PH_DRAIN   = 7'b0100000,
      PH_HALTED  = 7'b1000000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic [OFFSET_W-1:0] obu_start_ff, obu_start_in;
   logic [3:0]          kind_ff, kind_in;
   logic                size_flag_ff, size_flag_in;
   logic [5:0]          shift_ff, shift_in;
   logic [31:0]         left_ff, left_in;
   logic                too_large_ff, too_large_in;
   logic                open_ff, open_in;
   logic [OFFSET_W-1:0] unit_start_ff, unit_start_in;
   logic [OFFSET_W-1:0] unit_end_ff, unit_end_in;
   logic [CAP_W-1:0]    emitted_ff, emitted_in;

   logic [38:0]         shifted;
   logic [6:0]          shift_sum;
   logic                do_done;
   logic [CAP_W-1:0]    cap;
   logic [OFFSET_W-1:0] end_pos;
   logic [CAP_W-1:0]    emitted_less;

   function automatic otus_unit_type make_unit(
      input logic [OFFSET_W-1:0] start_pos,
      input logic [OFFSET_W-1:0] stop_pos,
      input logic [CAP_W-1:0]    count_less,
      input logic                halted,
      input logic                last
   );
      otus_unit_type u;
      u.start_pos = start_pos;
      u.end_pos   = stop_pos;
      u.number    = count_less[NUMBER_W-1:0];
      u.halted    = halted;
      u.last      = last;
      return u;
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      obu_start_in  = obu_start_ff;
      kind_in       = kind_ff;
      size_flag_in  = size_flag_ff;
      shift_in      = shift_ff;
      left_in       = left_ff;
      too_large_in  = too_large_ff;
      open_in       = open_ff;
      unit_start_in = unit_start_ff;
      unit_end_in   = unit_end_ff;
      emitted_in    = emitted_ff;
      push          = 1'b0;
      entry         = '0;
      do_done       = 1'b0;
      shifted       = '0;
      shift_sum     = '0;
      emitted_less  = '0;
      end_pos       = pos_ff + OFFSET_W'(1);
      cap           = (cap_setting > UNIT_CAP) ? UNIT_CAP : cap_setting;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               obu_start_in = pos_ff;
               kind_in      = req.stream_byte[6:3];
               size_flag_in = req.stream_byte[1];
               shift_in     = '0;
               left_in      = '0;
               too_large_in = 1'b0;
               if (req.stream_byte[2]) begin
                  phase_in = PH_EXT;
               end else begin
                  phase_in = req.stream_byte[1] ? PH_SIZE : PH_TO_END;
               end
            end
            PH_EXT: begin
               phase_in = size_flag_ff ? PH_SIZE : PH_TO_END;
            end
            PH_SIZE: begin
               // leb128 digit, shift is 0..28 while below 32
               if (!shift_ff[5]) begin
                  shifted      = {32'd0, req.stream_byte[6:0]} << shift_ff[4:0];
                  left_in      = left_ff | shifted[31:0];
                  too_large_in = too_large_ff | (|shifted[38:32]);
               end else begin
                  too_large_in = too_large_ff | (|req.stream_byte[6:0]);
               end
               shift_sum = {1'b0, shift_ff} + 7'd7;
               shift_in  = (shift_sum > 7'd63) ? 6'd63 : shift_sum[5:0];
               if (!req.stream_byte[7]) begin
                  if (too_large_in) begin
                     phase_in = PH_DRAIN;
                  end else if (left_in == '0) begin
                     do_done = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               left_in = left_ff - 32'd1;
               if (left_in == '0) begin
                  do_done = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // an obu without a size field ends with the stream
         if (req.end_of_stream && (phase_in == PH_TO_END)) begin
            do_done = 1'b1;
         end

         if (do_done) begin
            phase_in     = PH_HEADER;
            emitted_less = emitted_ff - CAP_W'(1);
            if ((kind_in == KIND_TEMPORAL_DELIM) || !open_ff) begin
               if (emitted_ff >= cap) begin
                  if (open_ff) begin
                     entry.first = make_unit(unit_start_ff, unit_end_ff, emitted_less,
                                             1'b1, 1'b1);
                     push = 1'b1;
                  end
                  open_in  = 1'b0;
                  phase_in = PH_HALTED;
               end else begin
                  if (open_ff) begin
                     entry.first = make_unit(unit_start_ff, unit_end_ff, emitted_less,
                                             1'b0, 1'b0);
                     push = 1'b1;
                  end
                  open_in       = 1'b1;
                  unit_start_in = obu_start_in;
                  unit_end_in   = end_pos;
                  emitted_in    = emitted_ff + CAP_W'(1);
               end
            end else begin
               unit_end_in = end_pos;
            end
         end

         if (req.end_of_stream) begin
            if ((phase_in != PH_HALTED) && open_in) begin
               if (push) begin
                  entry.second     = make_unit(unit_start_in, unit_end_in,
                                               emitted_in - CAP_W'(1), 1'b0, 1'b1);
                  entry.has_second = 1'b1;
               end else begin
                  entry.first = make_unit(unit_start_in, unit_end_in,
                                          emitted_in - CAP_W'(1), 1'b0, 1'b1);
                  push        = 1'b1;
               end
            end
            phase_in      = PH_HEADER;
            pos_in        = '0;
            obu_start_in  = '0;
            kind_in       = '0;
            size_flag_in  = 1'b0;
            shift_in      = '0;
            left_in       = '0;
            too_large_in  = 1'b0;
            open_in       = 1'b0;
            unit_start_in = '0;
            unit_end_in   = '0;
            emitted_in    = '0;
         end else begin
            pos_in = end_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         obu_start_ff  <= '0;
         kind_ff       <= '0;
         size_flag_ff  <= 1'b0;
         shift_ff      <= '0;
         left_ff       <= '0;
         too_large_ff  <= 1'b0;
         open_ff       <= 1'b0;
         unit_start_ff <= '0;
         unit_end_ff   <= '0;
         emitted_ff    <= '0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         obu_start_ff  <= obu_start_in;
         kind_ff       <= kind_in;
         size_flag_ff  <= size_flag_in;
         shift_ff      <= shift_in;
         left_ff       <= left_in;
         too_large_ff  <= too_large_in;
         open_ff       <= open_in;
         unit_start_ff <= unit_start_in;
         unit_end_ff   <= unit_end_in;
         emitted_ff    <= emitted_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/otus_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module otus_queue import otus_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire otus_entry_type push_entry,
   output logic                full,
   input  wire logic           pop,
   output logic                valid,
   output otus_entry_type      head
);

   otus_entry_type           slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   localparam logic [QUEUE_PTR_W-1:0] LAST_PTR  = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_PTR_W:0]   DEPTH_CNT = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

   assign full    = (count_ff == DEPTH_CNT);
   assign valid   = (count_ff != '0);
   assign head    = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/otus_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module otus_back import otus_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           q_valid,
   input  wire otus_entry_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output otus_rsp_type        rsp_data
);

   logic          second_ff, second_in;
   logic          rsp_valid_ff, rsp_valid_in;
   otus_rsp_type  rsp_data_ff, rsp_data_in;
   otus_unit_type cur;
   logic          load;

   assign load = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign cur  = second_ff ? q_head.second : q_head.first;

   always_comb begin
      rsp_data_in.unit_offset   = 32'(cur.start_pos);
      rsp_data_in.unit_length   = 32'(cur.end_pos - cur.start_pos);
      rsp_data_in.unit_number   = cur.number;
      rsp_data_in.halted_by_cap = cur.halted;
      rsp_data_in.last_result   = cur.last;

      q_pop        = load && (second_ff || !q_head.has_second);
      second_in    = load ? (!second_ff && q_head.has_second) : second_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/av1_obu_temporal_unit_splitter.sv */
`timescale 1ns / 1ps
`default_nettype none

// av1 obu temporal unit splitter
// req_ channel: one raw obu stream byte per transaction, end_of_stream on the last byte
// rsp_ channel: one transaction per temporal unit (offset, length, number, flags)
// csr_ port: csr_wr_en/csr_wr_data set the unit cap, write only while the block is idle
// throughput: one byte per clock while the queue is not full; a byte that closes a unit and ends the stream
//   yields two results, which leave one after the other
// path: a result travels from the byte that causes it
//   through a 4-entry queue and the output register
// the parser front only stalls when the 4-entry queue is full, so it keeps taking
//   bytes while the output register holds a result under rsp_stall
// rsp_stall holds the output register; the queue absorbs results until full,
//   then req_stall rises
// reset: parser state cleared, queue emptied, unit cap back to 4096, rsp_valid low

module av1_obu_temporal_unit_splitter import otus_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire otus_req_type     req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output otus_rsp_type          rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   // unit cap register
   logic [CAP_W-1:0] cap_setting_ff;

   // queue between parser and result stage
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_valid;
   otus_entry_type q_push_entry;
   otus_entry_type q_head;
   logic           req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_setting_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_setting_ff <= csr_wr_data;
      end
   end

   // front stalls on a full queue only
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   otus_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .req         (req_data),
      .cap_setting (cap_setting_ff),
      .push        (q_push),
      .entry       (q_push_entry)
   );

   otus_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   otus_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a parsed byte never lands in a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   // result stage only drains a queue that holds something
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

   // a cap halt always closes the stream's reporting
   a_halt_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.halted_by_cap) |-> rsp_data.last_result)
      else $error("halted result not marked last");

   // no stale result survives reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

/* test/av1_obu_temporal_unit_splitter_test.sv */
`timescale 1ns / 1ps

module av1_obu_temporal_unit_splitter_test import otus_pkg::*;;

   // watchdog: cycles without any transaction on either channel
   localparam int QUIET_LIMIT     = 4000;
   // receiver hold used to fill the result queue and push back on the input
   localparam int LONG_HOLD       = 200;
   // cycles allowed for an in-flight byte to surface before a register write
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 1200;

   // parser phases of the byte-level model
   typedef enum logic [2:0] {
      PARSE_HEADER,
      PARSE_EXTENSION,
      PARSE_SIZE,
      PARSE_PAYLOAD,
      PARSE_TO_END,
      PARSE_DRAIN,
      PARSE_HALTED
   } parse_phase_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   otus_req_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   otus_rsp_type       rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [CAP_W-1:0]   csr_wr_data = '0;

   av1_obu_temporal_unit_splitter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // unit predictor: byte-level parser state, mirrors the block
   // ---------------------------------------------------------------
   parse_phase_type    parse_phase;
   logic [31:0]        byte_pos;
   logic [31:0]        obu_start;
   logic [3:0]         obu_kind;
   logic               size_present;
   int unsigned        size_shift;
   logic [31:0]        payload_left;
   logic               size_too_large;
   logic               unit_open;
   logic [31:0]        unit_start;
   logic [31:0]        unit_end;
   logic [CAP_W-1:0]   units_opened;
   logic [CAP_W-1:0]   cap_setting;

   otus_rsp_type       expected_units[$];
   int unsigned        items_sent = 0;
   int unsigned        mismatch_count = 0;

   // test-side knobs, sampled by the driver and the receiver
   bit                 req_idle = 1'b1;
   bit                 rsp_idle = 1'b1;
   logic               hold_token = 1'b0;

   logic [7:0]         stream_bytes[$];

   function automatic void clear_parser();
      parse_phase    = PARSE_HEADER;
      byte_pos       = '0;
      obu_start      = '0;
      obu_kind       = '0;
      size_present   = 1'b0;
      size_shift     = 0;
      payload_left   = '0;
      size_too_large = 1'b0;
      unit_open      = 1'b0;
      unit_start     = '0;
      unit_end       = '0;
      units_opened   = '0;
   endfunction

   function automatic void report_unit(logic halted, logic last);
      otus_rsp_type unit;
      unit.unit_offset   = unit_start;
      unit.unit_length   = unit_end - unit_start;
      unit.unit_number   = 12'(units_opened - 13'd1);
      unit.halted_by_cap = halted;
      unit.last_result   = last;
      expected_units.push_back(unit);
   endfunction

   // an obu just completed; end_pos is one past its last byte
   function automatic void close_obu(logic [31:0] end_pos);
      logic [CAP_W-1:0] cap;
      cap = (cap_setting > UNIT_CAP) ? UNIT_CAP : cap_setting;
      parse_phase = PARSE_HEADER;
      if (obu_kind == KIND_TEMPORAL_DELIM || !unit_open) begin
         if (units_opened >= cap) begin
            // one unit too many: report what is open and stop parsing
            if (unit_open) report_unit(1'b1, 1'b1);
            unit_open   = 1'b0;
            parse_phase = PARSE_HALTED;
         end else begin
            if (unit_open) report_unit(1'b0, 1'b0);
            unit_open    = 1'b1;
            unit_start   = obu_start;
            unit_end     = end_pos;
            units_opened = units_opened + 13'd1;
         end
      end else begin
         unit_end = end_pos;
      end
   endfunction

   function automatic void predict_units(logic [7:0] b, logic eos);
      logic [31:0] end_pos;
      logic [63:0] size_acc;
      end_pos = byte_pos + 32'd1;
      items_sent++;
      case (parse_phase)
         PARSE_HEADER: begin
            // forbidden and reserved bits play no part
            obu_start      = byte_pos;
            obu_kind       = b[6:3];
            size_present   = b[1];
            size_shift     = 0;
            payload_left   = '0;
            size_too_large = 1'b0;
            if (b[2]) begin
               parse_phase = PARSE_EXTENSION;
            end else begin
               parse_phase = size_present ? PARSE_SIZE : PARSE_TO_END;
            end
         end
         PARSE_EXTENSION: begin
            parse_phase = size_present ? PARSE_SIZE : PARSE_TO_END;
         end
         PARSE_SIZE: begin
            // leb128 group; anything that lands above bit 31 never completes
            if (size_shift < 32) begin
               size_acc = {32'd0, payload_left} | ({57'd0, b[6:0]} << size_shift);
               if (size_acc[63:32] != '0) size_too_large = 1'b1;
               payload_left = size_acc[31:0];
            end else if (b[6:0] != '0) begin
               size_too_large = 1'b1;
            end
            size_shift = (size_shift + 7 > 63) ? 63 : size_shift + 7;
            if (!b[7]) begin
               if (size_too_large) begin
                  parse_phase = PARSE_DRAIN;
               end else if (payload_left == '0) begin
                  close_obu(end_pos);
               end else begin
                  parse_phase = PARSE_PAYLOAD;
               end
            end
         end
         PARSE_PAYLOAD: begin
            payload_left = payload_left - 32'd1;
            if (payload_left == '0) close_obu(end_pos);
         end
         default: ;
      endcase
      if (eos) begin
         // an obu with no size field ends with the stream
         if (parse_phase == PARSE_TO_END) close_obu(end_pos);
         if (parse_phase != PARSE_HALTED && unit_open) report_unit(1'b0, 1'b1);
         clear_parser();
      end else begin
         byte_pos = end_pos;
      end
   endfunction

   // ---------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_byte(input logic [7:0] b, input logic eos);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{stream_byte: b, end_of_stream: eos};
      do @(posedge clock); while (req_stall);
      predict_units(b, eos);
   endtask

   task automatic send_stream();
      foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   // drop valid and wait for every predicted unit to come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_units.size() != 0);
   endtask

   // register writes only between streams with the block idle
   task automatic write_cap_setting(input logic [CAP_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = value;
   endtask

   // ---------------------------------------------------------------
   // stream construction
   // ---------------------------------------------------------------
   function automatic void push_leb(logic [31:0] value, int unsigned pad);
      logic [6:0] group;
      int unsigned i;
      // pad adds redundant zero groups, which can push the shift past 32
      do begin
         group = value[6:0];
         value = value >> 7;
         stream_bytes.push_back({(value != '0 || pad != 0), group});
      end while (value != '0);
      for (i = 0; i < pad; i++) stream_bytes.push_back({(i + 1 < pad), 7'd0});
   endfunction

   function automatic void push_obu(logic [3:0] kind, logic ext, logic sized,
                                    int unsigned len);
      logic [7:0] header;
      header = {1'($urandom), kind, ext, sized, 1'($urandom)};
      stream_bytes.push_back(header);
      if (ext) stream_bytes.push_back(8'($urandom));
      if (sized) push_leb(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0);
      repeat (len) stream_bytes.push_back(8'($urandom));
   endfunction

   // mostly well-formed obu sequences, some broken ones, some raw noise
   function automatic void build_random_stream();
      int unsigned shape;
      int unsigned obu_total;
      int unsigned len;
      int unsigned cut;
      logic [3:0]  kind;
      logic        sized;
      stream_bytes.delete();
      shape = $urandom_range(0, 19);
      if (shape < 2) begin
         repeat ($urandom_range(1, 24)) stream_bytes.push_back(8'($urandom));
      end else begin
         obu_total = $urandom_range(1, 8);
         for (int i = 0; i < obu_total; i++) begin
            kind = ($urandom_range(0, 2) == 0) ? KIND_TEMPORAL_DELIM : 4'($urandom);
            if (kind == KIND_TEMPORAL_DELIM) begin
               len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            end else if ($urandom_range(0, 30) == 0) begin
               len = $urandom_range(100, 300);
            end else begin
               len = $urandom_range(0, 10);
            end
            // an unsized obu only makes sense as the last one
            sized = !(i == obu_total - 1 && $urandom_range(0, 4) == 0);
            push_obu(kind, 1'($urandom), sized, len);
         end
         if ($urandom_range(0, 9) == 0) begin
            // size field that overflows 32 bits, followed by junk
            stream_bytes.push_back({1'($urandom), 4'($urandom), 1'($urandom), 1'b1,
                                    1'($urandom)});
            if ($urandom_range(0, 1) == 0) begin
               repeat (4) stream_bytes.push_back(8'hFF);
               stream_bytes.push_back({1'b0, 3'($urandom_range(1, 7)), 4'($urandom)});
            end else begin
               repeat (5) stream_bytes.push_back(8'h80);
               stream_bytes.push_back({1'b0, 7'($urandom_range(1, 127))});
            end
            repeat ($urandom_range(0, 6)) stream_bytes.push_back(8'($urandom));
         end
         if ($urandom_range(0, 7) == 0 && stream_bytes.size() > 1) begin
            // truncated tail: bytes cut off the end, so the last obu may never complete
            cut = $urandom_range(1, (stream_bytes.size() > 7) ? 6 : stream_bytes.size() - 1);
            repeat (cut) void'(stream_bytes.pop_back());
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // result receiver and checker
   // ---------------------------------------------------------------
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   logic        hold_seen = 1'b0;

   function automatic void check_unit(otus_rsp_type got);
      otus_rsp_type want;
      if (expected_units.size() == 0) begin
         $error("unexpected unit transaction: offset %0d length %0d number %0d",
                got.unit_offset, got.unit_length, got.unit_number);
         mismatch_count++;
         return;
      end
      want = expected_units.pop_front();
      if (got.unit_offset !== want.unit_offset) begin
         $error("unit_offset: expected %0d, got %0d", want.unit_offset, got.unit_offset);
         mismatch_count++;
      end
      if (got.unit_length !== want.unit_length) begin
         $error("unit_length: expected %0d, got %0d", want.unit_length, got.unit_length);
         mismatch_count++;
      end
      if (got.unit_number !== want.unit_number) begin
         $error("unit_number: expected %0d, got %0d", want.unit_number, got.unit_number);
         mismatch_count++;
      end
      if (got.halted_by_cap !== want.halted_by_cap) begin
         $error("halted_by_cap: expected %0b, got %0b", want.halted_by_cap,
                got.halted_by_cap);
         mismatch_count++;
      end
      if (got.last_result !== want.last_result) begin
         $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_unit(rsp_data);
            stall_left = rsp_idle ? $urandom_range(0, 15) : 0;
         end
         // a flip of hold_token starts a long hold counted here
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on progress of either channel
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // hand-made streams at reset cap, then a cap of one
   task automatic test_directed_cases();
      // two units, header with every bit set, two results on the final byte
      stream_bytes = '{8'h12, 8'h00, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h12, 8'h00};
      send_stream();
      // stream ends before the extension byte: nothing reported
      stream_bytes = '{8'h14};
      send_stream();
      // oversized leb128 size: rest of stream skipped, open unit still reported
      stream_bytes = '{8'h12, 8'h00, 8'h0A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F, 8'h00};
      send_stream();
      // cap of one: second delimiter halts, later bytes ignored
      write_cap_setting(13'd1);
      stream_bytes = '{8'h12, 8'h00, 8'h12, 8'h00, 8'h12, 8'h00};
      send_stream();
   endtask

   // random streams across several caps and idling mixes
   task automatic test_random_streams();
      logic [CAP_W-1:0] cap;
      int unsigned      goal;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: cap = CAP_RESET;
            1: cap = 13'd1;
            2: cap = 13'($urandom_range(2, 8));
            3: cap = UNIT_CAP;
            4: cap = 13'($urandom_range(1, 4096));
            default: cap = 13'd2;
         endcase
         write_cap_setting(cap);
         // phase 2 runs both sides flat out, others mix idling
         req_idle = (phase != 2) && (phase != 4);
         rsp_idle = (phase != 2) && (phase != 5);
         goal = items_sent + RANDOM_ITEMS / 6;
         while (items_sent < goal) begin
            build_random_stream();
            send_stream();
         end
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // receiver holds off while delimiter-heavy streams keep coming
   task automatic test_output_backpressure();
      write_cap_setting(UNIT_CAP);
      req_idle = 1'b0;
      hold_token <= ~hold_token;
      repeat (3) begin
         stream_bytes.delete();
         repeat (12) push_obu(KIND_TEMPORAL_DELIM, 1'b0, 1'b1, 0);
         send_stream();
      end
      wait_drained();
      req_idle = 1'b1;
   endtask

   // sender stops mid-stream until every unit so far has come out
   task automatic test_sender_pause();
      int unsigned half;
      stream_bytes.delete();
      repeat (4) push_obu(KIND_TEMPORAL_DELIM, 1'($urandom), 1'b1, $urandom_range(0, 3));
      push_obu(4'd6, 1'b0, 1'b1, 5);
      half = stream_bytes.size() / 2;
      foreach (stream_bytes[i]) begin
         if (i == half) wait_drained();
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
      end
   endtask

   initial begin
      clear_parser();
      cap_setting = CAP_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_streams();
      test_output_backpressure();
      test_sender_pause();

      // let the tail settle, then report
      wait_drained();
      repeat (SETTLE_CYCLES + 2) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* av1_obu_temporal_unit_splitter.f */
hw/rtl/otus_pkg.sv
hw/rtl/otus_front.sv
hw/rtl/otus_queue.sv
hw/rtl/otus_back.sv
hw/rtl/av1_obu_temporal_unit_splitter.sv
test/av1_obu_temporal_unit_splitter_test.sv
